@@ hw/rtl/websocket_frame_deframer_core_macros.svh @@
// Assertion macros used by the deframer top-level RTL file.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every rising clock edge outside reset.
`define WSD_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`else

`define WSD_ASSERT(lbl, clk, rst_n, cond, msg)
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)

`endif

`endif

@@ hw/rtl/wsd_pkg.sv @@
// Types and constants of the WebSocket frame deframer.
package wsd_pkg;

    // Parser phases
    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_MASK = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;

    // Frame opcodes
    localparam logic [3:0] OP_CONT       = 4'h0;
    localparam logic [3:0] OP_TEXT       = 4'h1;
    localparam logic [3:0] OP_BIN        = 4'h2;
    localparam logic [3:0] OP_CONN_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING       = 4'h9;

    // Result kinds
    localparam logic [2:0] KIND_MSG_BYTE   = 3'd0;
    localparam logic [2:0] KIND_MSG_EMPTY  = 3'd1;
    localparam logic [2:0] KIND_PONG_BYTE  = 3'd2;
    localparam logic [2:0] KIND_PONG_EMPTY = 3'd3;
    localparam logic [2:0] KIND_ECHO_BYTE  = 3'd4;
    localparam logic [2:0] KIND_CLOSE_EVT  = 3'd5;
    localparam logic [2:0] KIND_ERROR      = 3'd6;

    // Header length codes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Close status codes and limits
    localparam logic [15:0] CLOSE_NO_STATUS = 16'd1005;
    localparam logic [15:0] CLOSE_ABNORMAL  = 16'd1006;
    localparam logic [6:0]  ECHO_MAX        = 7'd125;

    // Configuration register indexes and reset values
    localparam logic CFG_MAX_PAYLOAD = 1'b0;
    localparam logic CFG_ECHO_LIMIT  = 1'b1;
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'h1000_0000;

    typedef struct packed {
        logic [2:0]  phase;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] length;
        logic [3:0]  hdr_count;
        logic [31:0] mask_key;
        logic [31:0] index;
        logic        type_known;
        logic        type_binary;
        logic [15:0] close_code;
        logic        closed;
        logic        error;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        payload_end;
        logic        msg_binary;
        logic [15:0] close_code;
        logic        run_last;
    } result_t;

    typedef struct packed {
        logic [1:0]   count;
        result_t      res0;
        result_t      res1;
        parse_state_t state;
    } step_out_t;

endpackage

@@ hw/rtl/websocket_frame_deframer_core.sv @@
// Top level of the WebSocket receive-side frame deframer.
//
// The block parses a received WebSocket byte stream, one byte per input item,
// and emits unmasked message, pong-echo and close-echo bytes plus end marks,
// close events and an error result. Each accepted item is parsed in the same
// cycle against the registered parser state; its zero, one or two results are
// pushed into a small output queue (OUT_DEPTH entries), so a new byte can be
// taken in every cycle while earlier results still wait downstream. An input
// item is taken whenever the queue has room for two results. Throughput is one
// byte per cycle, set by the single-result-per-cycle output port: only the
// last byte of an echoed close frame produces two results (echo byte, then the
// close event). Input tuser[0] marks a link-down event, whose byte is ignored.
// After a close event the block stays closed until reset; after an oversized
// length it drops all bytes but still reports link loss. No clearing pass is
// needed after reset. Write configuration only while the block is idle.
module websocket_frame_deframer_core
    import wsd_pkg::*;
#(
    parameter int OUT_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] link_down

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [8] payload_end,
                                        // [24:9] close_code, [31:25] zero
    output logic [3:0]  m_axis_tuser,   // [2:0] out_kind, [3] msg_binary
    output logic        m_axis_tlast,   // run_last

    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

`include "websocket_frame_deframer_core_macros.svh"

    parse_state_t state_reg;
    logic [31:0]  max_payload_reg;
    logic [6:0]   echo_limit_reg;
    step_out_t    step;
    logic         in_accept;
    logic [1:0]   push_count;
    result_t      head;
    logic         room2;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign push_count = in_accept ? step.count : 2'd0;

    // Parse the presented byte against the current state.
    wsd_step u_step (
        .st               (state_reg),
        .max_payload      (max_payload_reg),
        .close_echo_limit (echo_limit_reg),
        .rx_byte          (s_axis_tdata),
        .link_down        (s_axis_tuser[0]),
        .step             (step)
    );

    // Advance the parser state on every accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= step.state;
        end
    end

    // Configuration registers: write-only, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
            echo_limit_reg  <= ECHO_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                CFG_ECHO_LIMIT:  echo_limit_reg  <= cfg_data[6:0];
                default:         ;
            endcase
        end
    end

    // Hold results until the downstream side takes them.
    wsd_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (step.res0),
        .push1      (step.res1),
        .pop        (m_axis_tready),
        .head       (head),
        .not_empty  (m_axis_tvalid),
        .room2      (room2)
    );

    assign s_axis_tready = room2;
    assign m_axis_tdata  = {7'd0, head.close_code, head.payload_end, head.data};
    assign m_axis_tuser  = {head.msg_binary, head.kind};
    assign m_axis_tlast  = head.run_last;

    `WSD_ASSERT(a_closed_silent, clk, rst_n,
        !(in_accept && state_reg.closed && step.count != 2'd0),
        "closed block produced a result")
    `WSD_ASSERT_NEXT(a_closed_sticky, clk, rst_n, state_reg.closed, state_reg.closed,
        "closed flag cleared without reset")
    `WSD_ASSERT_NEXT(a_error_sticky, clk, rst_n, state_reg.error, state_reg.error,
        "error flag cleared without reset")
    `WSD_ASSERT(a_pair_is_close, clk, rst_n,
        !(in_accept && step.count == 2'd2) || (step.res0.kind == KIND_ECHO_BYTE &&
        step.res1.kind == KIND_CLOSE_EVT),
        "two results from one byte other than echo plus close event")

endmodule

@@ hw/rtl/wsd_step.sv @@
// Per-byte parse step: next parser state and up to two results.
module wsd_step
    import wsd_pkg::*;
(
    input  parse_state_t st,
    input  logic [31:0]  max_payload,
    input  logic [6:0]   close_echo_limit,
    input  logic [7:0]   rx_byte,
    input  logic         link_down,
    output step_out_t    step
);

    function automatic result_t mk_res(logic [2:0] kind, logic [7:0] data, logic pend,
                                       logic bin, logic [15:0] code);
        result_t r;
        r.kind        = kind;
        r.data        = data;
        r.payload_end = pend;
        r.msg_binary  = bin;
        r.close_code  = code;
        r.run_last    = 1'b0;
        return r;
    endfunction

    parse_state_t ns;
    result_t      res [2];
    logic [1:0]   cnt;
    logic         do_len;
    logic         do_start;
    logic         do_finish;
    logic         is_data;
    logic [7:0]   key_byte;
    logic [7:0]   b_um;
    logic [31:0]  idx_inc;
    logic         last;
    logic [6:0]   lim;
    logic [6:0]   echo_len;

    assign is_data = (st.opcode inside {OP_CONT, OP_TEXT, OP_BIN});

    always_comb
    begin
        ns        = st;
        cnt       = 2'd0;
        res[0]    = '0;
        res[1]    = '0;
        do_len    = 1'b0;
        do_start  = 1'b0;
        do_finish = 1'b0;
        idx_inc   = st.index + 32'd1;
        key_byte  = 8'(st.mask_key >> (5'd24 - {st.index[1:0], 3'b000}));
        b_um      = st.masked ? (rx_byte ^ key_byte) : rx_byte;
        last      = (idx_inc == st.length[31:0]);
        lim       = (close_echo_limit > ECHO_MAX) ? ECHO_MAX : close_echo_limit;
        echo_len  = (st.length < 64'(lim)) ? st.length[6:0] : lim;

        if (!st.closed)
        begin
            if (link_down)
            begin
                ns.closed = 1'b1;
                res[0]    = mk_res(KIND_CLOSE_EVT, 8'd0, 1'b0, 1'b0, CLOSE_ABNORMAL);
                cnt       = 2'd1;
            end
            else if (!st.error)
            begin
                case (st.phase)
                    PH_HDR0:
                    begin
                        ns.fin    = rx_byte[7];
                        ns.opcode = rx_byte[3:0];
                        ns.phase  = PH_HDR1;
                    end
                    PH_HDR1:
                    begin
                        ns.masked    = rx_byte[7];
                        ns.length    = {57'd0, rx_byte[6:0]};
                        ns.hdr_count = 4'd0;
                        if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64)
                        begin
                            ns.hdr_count = (rx_byte[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                            ns.length    = 64'd0;
                            ns.phase     = PH_EXT;
                        end
                        else
                        begin
                            do_len = 1'b1;
                        end
                    end
                    PH_EXT:
                    begin
                        ns.length    = {st.length[55:0], rx_byte};
                        ns.hdr_count = st.hdr_count - 4'd1;
                        do_len       = (ns.hdr_count == 4'd0);
                    end
                    PH_MASK:
                    begin
                        ns.mask_key  = {st.mask_key[23:0], rx_byte};
                        ns.hdr_count = st.hdr_count + 4'd1;
                        do_start     = (ns.hdr_count >= 4'd4);
                    end
                    PH_PAY:
                    begin
                        if (is_data)
                        begin
                            res[0] = mk_res(KIND_MSG_BYTE, b_um, last && st.fin,
                                            st.type_binary, 16'd0);
                            cnt    = 2'd1;
                        end
                        else if (st.opcode == OP_PING)
                        begin
                            res[0] = mk_res(KIND_PONG_BYTE, b_um, last, 1'b0, 16'd0);
                            cnt    = 2'd1;
                        end
                        else if (st.opcode == OP_CONN_CLOSE)
                        begin
                            // first two payload bytes carry the status, big-endian
                            if (st.index == 32'd0)
                            begin
                                ns.close_code = {b_um, 8'd0};
                            end
                            else if (st.index == 32'd1)
                            begin
                                ns.close_code = {st.close_code[15:8], b_um};
                            end
                            if (st.index < 32'(echo_len))
                            begin
                                res[0] = mk_res(KIND_ECHO_BYTE, b_um,
                                                idx_inc == 32'(echo_len), 1'b0, 16'd0);
                                cnt    = 2'd1;
                            end
                        end
                        ns.index  = idx_inc;
                        do_finish = last;
                    end
                    default:
                    begin
                        ns.phase = PH_HDR0;
                    end
                endcase
            end
        end

        if (do_len)
        begin
            if (ns.length > {32'd0, max_payload})
            begin
                ns.error = 1'b1;
                ns.phase = PH_HDR0;
                res[0]   = mk_res(KIND_ERROR, 8'd0, 1'b0, 1'b0, 16'd0);
                cnt      = 2'd1;
            end
            else if (ns.masked)
            begin
                ns.hdr_count = 4'd0;
                ns.phase     = PH_MASK;
            end
            else
            begin
                do_start = 1'b1;
            end
        end

        if (do_start)
        begin
            ns.index = 32'd0;
            if ((st.opcode == OP_TEXT || st.opcode == OP_BIN) && !st.type_known)
            begin
                ns.type_known  = 1'b1;
                ns.type_binary = (st.opcode == OP_BIN);
            end
            if (ns.length == 64'd0)
            begin
                do_finish = 1'b1;
            end
            else
            begin
                ns.phase = PH_PAY;
            end
        end

        if (do_finish)
        begin
            if (is_data)
            begin
                if (st.fin)
                begin
                    if (ns.length == 64'd0)
                    begin
                        res[cnt[0]] = mk_res(KIND_MSG_EMPTY, 8'd0, 1'b1, ns.type_binary,
                                             16'd0);
                        cnt         = cnt + 2'd1;
                    end
                    ns.type_known = 1'b0;
                end
            end
            else if (st.opcode == OP_PING)
            begin
                if (ns.length == 64'd0)
                begin
                    res[cnt[0]] = mk_res(KIND_PONG_EMPTY, 8'd0, 1'b1, 1'b0, 16'd0);
                    cnt         = cnt + 2'd1;
                end
            end
            else if (st.opcode == OP_CONN_CLOSE)
            begin
                res[cnt[0]] = mk_res(KIND_CLOSE_EVT, 8'd0, 1'b0, 1'b0,
                                     (ns.length >= 64'd2) ? ns.close_code : CLOSE_NO_STATUS);
                cnt         = cnt + 2'd1;
                ns.closed   = 1'b1;
            end
            ns.phase = PH_HDR0;
        end

        if (cnt != 2'd0)
        begin
            res[1'(cnt - 2'd1)].run_last = 1'b1;
        end
    end

    assign step.count = cnt;
    assign step.res0  = res[0];
    assign step.res1  = res[1];
    assign step.state = ns;

endmodule

@@ hw/rtl/wsd_fifo.sv @@
// Result queue: takes up to two results per cycle, delivers one.
module wsd_fifo
    import wsd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  result_t    push0,
    input  result_t    push1,
    input  logic       pop,
    output result_t    head,
    output logic       not_empty,
    output logic       room2
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    result_t        mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  wr_ptr_plus1;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_pop;

    assign do_pop       = pop && not_empty;
    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
    assign wr_ptr_next  = (push_count == 2'd2) ? ptr_inc(wr_ptr_plus1) :
                          (push_count == 2'd1) ? wr_ptr_plus1 : wr_ptr_reg;
    assign count_next   = count_reg + CW'(push_count) - CW'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push1;
        end
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room2     = (count_reg <= CW'(DEPTH - 2));

endmodule

@@ bench/websocket_frame_deframer_core_tb.sv @@
// Self-checking bench for the WebSocket receive-side frame deframer core.
module websocket_frame_deframer_core_tb;
    import wsd_pkg::*;

    // Opcodes the package leaves out: pong and the two reserved ranges
    localparam logic [3:0] OP_PONG        = 4'hA;
    localparam logic [3:0] OP_RSV_DATA_LO = 4'h3;
    localparam logic [3:0] OP_RSV_DATA_HI = 4'h7;
    localparam logic [3:0] OP_RSV_CTRL_LO = 4'hB;
    localparam logic [3:0] OP_RSV_CTRL_HI = 4'hF;

    // Header length forms
    localparam int FORM_SHORT = 0;
    localparam int FORM_EXT16 = 1;
    localparam int FORM_EXT64 = 2;

    // Ways the run can end (the block stays closed until reset)
    localparam int END_CLOSE_FRAME = 0;
    localparam int END_OVERSIZE    = 1;
    localparam int END_LINK_LOSS   = 2;

    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 150;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic       link_down;
        logic [7:0] data;
    } rx_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #5 clk = ~clk;

    websocket_frame_deframer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Byte stream waiting to be sent, and deframer output still owed by the block
    rx_item_t rx_stream[$];
    result_t  deframed_due[$];

    int items_queued = 0;
    int items_accepted = 0;
    int frames_queued = 0;
    int results_checked = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int cfg_writes = 0;

    // Configuration as currently written to the block
    logic [31:0] cur_max_len = MAX_PAYLOAD_RST;
    logic [6:0]  cur_echo_limit = ECHO_MAX;

    // Shadow parser state
    logic [2:0]  sh_phase = PH_HDR0;
    logic        sh_fin = 1'b0;
    logic [3:0]  sh_op = OP_CONT;
    logic        sh_masked = 1'b0;
    logic [63:0] sh_len = '0;
    logic [3:0]  sh_hdr = '0;
    logic [31:0] sh_key = '0;
    logic [31:0] sh_idx = '0;
    logic        sh_type_known = 1'b0;
    logic        sh_type_bin = 1'b0;
    logic [15:0] sh_code = '0;
    logic        sh_closed = 1'b0;
    logic        sh_error = 1'b0;

    result_t step_buf[2];
    int      step_n;

    //------------------------------------------------------------------
    // Shadow deframer
    //------------------------------------------------------------------
    function automatic logic is_data_op(input logic [3:0] op);
        return op == OP_CONT || op == OP_TEXT || op == OP_BIN;
    endfunction

    // Collect one result of the current byte; at most two per byte
    task automatic add_result(input logic [2:0] kind, input logic [7:0] data,
                              input logic pend, input logic bin, input logic [15:0] code);
        result_t r;
        r.kind        = kind;
        r.data        = data;
        r.payload_end = pend;
        r.msg_binary  = bin;
        r.close_code  = code;
        r.run_last    = 1'b0;
        if (step_n < 2) begin
            step_buf[step_n] = r;
            step_n++;
        end
    endtask

    // Wrap up a frame: end marks, close event, type release
    task automatic end_frame();
        if (is_data_op(sh_op)) begin
            if (sh_fin) begin
                if (sh_len == 0)
                    add_result(KIND_MSG_EMPTY, 8'h00, 1'b1, sh_type_bin, 16'h0);
                sh_type_known = 1'b0;
            end
        end else if (sh_op == OP_PING) begin
            if (sh_len == 0)
                add_result(KIND_PONG_EMPTY, 8'h00, 1'b1, 1'b0, 16'h0);
        end else if (sh_op == OP_CONN_CLOSE) begin
            add_result(KIND_CLOSE_EVT, 8'h00, 1'b0, 1'b0,
                       (sh_len >= 2) ? sh_code : CLOSE_NO_STATUS);
            sh_closed = 1'b1;
        end
        sh_phase = PH_HDR0;
    endtask

    // First text or binary frame of a message fixes the message type
    task automatic enter_payload();
        sh_idx = '0;
        if ((sh_op == OP_TEXT || sh_op == OP_BIN) && !sh_type_known) begin
            sh_type_known = 1'b1;
            sh_type_bin   = (sh_op == OP_BIN);
        end
        if (sh_len == 0)
            end_frame();
        else
            sh_phase = PH_PAY;
    endtask

    task automatic length_done();
        if (sh_len > {32'h0, cur_max_len}) begin
            sh_error = 1'b1;
            add_result(KIND_ERROR, 8'h00, 1'b0, 1'b0, 16'h0);
            sh_phase = PH_HDR0;
        end else if (sh_masked) begin
            sh_hdr   = '0;
            sh_phase = PH_MASK;
        end else begin
            enter_payload();
        end
    endtask

    task automatic payload_byte(input logic [7:0] raw);
        logic [7:0]  b;
        logic [63:0] pos_next;
        logic [63:0] lim;
        logic [63:0] echo_len;
        logic        last;
        b        = raw;
        pos_next = {32'h0, sh_idx} + 64'd1;
        last     = (pos_next == sh_len);
        // Key bytes apply most significant first, cycling every four bytes
        if (sh_masked) begin
            case (sh_idx[1:0])
                2'd0: b = b ^ sh_key[31:24];
                2'd1: b = b ^ sh_key[23:16];
                2'd2: b = b ^ sh_key[15:8];
                default: b = b ^ sh_key[7:0];
            endcase
        end
        if (is_data_op(sh_op)) begin
            add_result(KIND_MSG_BYTE, b, last && sh_fin, sh_type_bin, 16'h0);
        end else if (sh_op == OP_PING) begin
            add_result(KIND_PONG_BYTE, b, last, 1'b0, 16'h0);
        end else if (sh_op == OP_CONN_CLOSE) begin
            lim      = (cur_echo_limit > ECHO_MAX) ? {57'h0, ECHO_MAX} : {57'h0, cur_echo_limit};
            echo_len = (sh_len < lim) ? sh_len : lim;
            if (sh_idx == 0)
                sh_code = {b, 8'h00};
            else if (sh_idx == 1)
                sh_code = sh_code | {8'h00, b};
            if ({32'h0, sh_idx} < echo_len)
                add_result(KIND_ECHO_BYTE, b, pos_next == echo_len, 1'b0, 16'h0);
        end
        sh_idx = sh_idx + 32'd1;
        if (last)
            end_frame();
    endtask

    // Advance the shadow parser by one accepted item and queue what it owes
    task automatic deframe_step(input logic [7:0] b, input logic ld);
        int k;
        step_n = 0;
        if (!sh_closed) begin
            if (ld) begin
                sh_closed = 1'b1;
                add_result(KIND_CLOSE_EVT, 8'h00, 1'b0, 1'b0, CLOSE_ABNORMAL);
            end else if (!sh_error) begin
                case (sh_phase)
                    PH_HDR0: begin
                        sh_fin   = b[7];
                        sh_op    = b[3:0];
                        sh_phase = PH_HDR1;
                    end
                    PH_HDR1: begin
                        sh_masked = b[7];
                        sh_len    = {57'h0, b[6:0]};
                        sh_hdr    = '0;
                        if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                            sh_hdr   = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                            sh_len   = '0;
                            sh_phase = PH_EXT;
                        end else begin
                            length_done();
                        end
                    end
                    PH_EXT: begin
                        sh_len = {sh_len[55:0], b};
                        sh_hdr = sh_hdr - 4'd1;
                        if (sh_hdr == 0)
                            length_done();
                    end
                    PH_MASK: begin
                        sh_key = {sh_key[23:0], b};
                        sh_hdr = sh_hdr + 4'd1;
                        if (sh_hdr >= 4)
                            enter_payload();
                    end
                    PH_PAY:  payload_byte(b);
                    default: sh_phase = PH_HDR0;
                endcase
            end
        end
        for (k = 0; k < step_n; k++) begin
            if (k == step_n - 1)
                step_buf[k].run_last = 1'b1;
            deframed_due.push_back(step_buf[k]);
        end
    endtask

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    // Idle length for one side: mostly none, some short, a few long,
    // with occasional calm stretches that never idle
    function automatic int draw_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r < 2) begin
            calm = $urandom_range(40, 160);
            return 0;
        end
        if (r < 120) return 0;
        if (r < 180) return $urandom_range(1, 3);
        if (r < 196) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic int pick_form(input logic [63:0] len);
        int r;
        r = $urandom_range(0, 99);
        if (len <= 125) begin
            if (r < 80) return FORM_SHORT;
            if (r < 92) return FORM_EXT16;
            return FORM_EXT64;
        end
        if (len <= 65535 && r < 85) return FORM_EXT16;
        return FORM_EXT64;
    endfunction

    task automatic push_item(input logic [7:0] data, input logic ld);
        rx_item_t it;
        it.data      = data;
        it.link_down = ld;
        rx_stream.push_back(it);
        items_queued++;
    endtask

    // Queue one frame header and the first 'sent' payload bytes
    task automatic queue_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                               input logic masked, input logic [63:0] len, input int form,
                               input int sent);
        logic [31:0] key;
        int i;
        key = $urandom;
        push_item({fin, rsv, op}, 1'b0);
        case (form)
            FORM_SHORT: push_item({masked, len[6:0]}, 1'b0);
            FORM_EXT16: begin
                push_item({masked, LEN_EXT16}, 1'b0);
                push_item(len[15:8], 1'b0);
                push_item(len[7:0], 1'b0);
            end
            default: begin
                push_item({masked, LEN_EXT64}, 1'b0);
                for (i = 7; i >= 0; i--)
                    push_item(len[8*i +: 8], 1'b0);
            end
        endcase
        if (masked)
            for (i = 3; i >= 0; i--)
                push_item(key[8*i +: 8], 1'b0);
        for (i = 0; i < sent; i++)
            push_item(8'($urandom_range(0, 255)), 1'b0);
        frames_queued++;
    endtask

    // Well-formed frame with random content; never a close, never oversized
    task automatic queue_random_frame(input logic [31:0] len_cap);
        int r;
        logic [3:0]  op;
        logic [63:0] len;
        logic        fin;
        r = $urandom_range(0, 99);
        if (r < 25)      op = OP_TEXT;
        else if (r < 40) op = OP_BIN;
        else if (r < 60) op = OP_CONT;
        else if (r < 73) op = OP_PING;
        else if (r < 83) op = OP_PONG;
        else if (r < 92) op = 4'($urandom_range(OP_RSV_DATA_LO, OP_RSV_DATA_HI));
        else             op = 4'($urandom_range(OP_RSV_CTRL_LO, OP_RSV_CTRL_HI));
        r = $urandom_range(0, 99);
        if (r < 75)      len = 64'($urandom_range(0, 8));
        else if (r < 95) len = 64'($urandom_range(9, 40));
        else             len = 64'($urandom_range(120, 300));
        if (len > {32'h0, len_cap})
            len = 64'($urandom_range(0, len_cap));
        fin = is_data_op(op) ? 1'($urandom_range(0, 9) < 7) : 1'($urandom_range(0, 1));
        queue_frame(fin, 3'($urandom_range(0, 7)), op, 1'($urandom_range(0, 1)), len,
                    pick_form(len), int'(len));
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_MAX_PAYLOAD)
            cur_max_len = value;
        else
            cur_echo_limit = value[6:0];
        cfg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every byte is taken and every owed result has left the block
    task automatic wait_idle();
        while (rx_stream.size() != 0 || deframed_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    //------------------------------------------------------------------
    // Input driver: offer the head of rx_stream, predict on acceptance
    //------------------------------------------------------------------
    int tx_gap = 0;
    int tx_calm = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_step(s_axis_tdata, s_axis_tuser[0]);
                void'(rx_stream.pop_front());
                items_accepted++;
                tx_gap = draw_idle(tx_calm);
            end
            // Hold the offered item until it is taken
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (rx_stream.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= rx_stream[0].data;
                    s_axis_tuser  <= rx_stream[0].link_down;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Output monitor: compare each taken result with the oldest owed one
    //------------------------------------------------------------------
    int      rx_hold = 0;
    int      rx_calm = 0;
    int      rx_draw;
    logic    long_hold_done = 1'b0;
    result_t got_res;
    result_t want_res;

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_res.kind        = m_axis_tuser[2:0];
                got_res.data        = m_axis_tdata[7:0];
                got_res.payload_end = m_axis_tdata[8];
                got_res.msg_binary  = m_axis_tuser[3];
                got_res.close_code  = m_axis_tdata[24:9];
                got_res.run_last    = m_axis_tlast;
                if (deframed_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] unexpected result: kind %0d byte %02h end %b bin %b code %0d last %b",
                                 $time, got_res.kind, got_res.data, got_res.payload_end,
                                 got_res.msg_binary, got_res.close_code, got_res.run_last);
                end else begin
                    want_res = deframed_due.pop_front();
                    results_checked++;
                    if (got_res !== want_res || m_axis_tdata[31:25] !== 7'h00) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("[%0t] result %0d mismatch (pad %02h)", $time,
                                     results_checked, m_axis_tdata[31:25]);
                            $display("    expected kind %0d byte %02h end %b bin %b code %0d last %b",
                                     want_res.kind, want_res.data, want_res.payload_end,
                                     want_res.msg_binary, want_res.close_code, want_res.run_last);
                            $display("    actual   kind %0d byte %02h end %b bin %b code %0d last %b",
                                     got_res.kind, got_res.data, got_res.payload_end,
                                     got_res.msg_binary, got_res.close_code, got_res.run_last);
                        end
                    end
                end
            end
            // One long hold-off once the stream is well under way, so the
            // output queue fills and the block backs up its input
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (!long_hold_done && items_accepted >= 200) begin
                long_hold_done = 1'b1;
                rx_hold = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else begin
                rx_draw = draw_idle(rx_calm);
                if (rx_draw == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    rx_hold = rx_draw - 1;
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles: %0d items left, %0d results owed",
                     cycle_count, rx_stream.size(), deframed_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------
    initial begin
        int ending;
        int r;
        int n;
        logic [63:0] len;
        string ending_name;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty message end, masked binary start, extended-length
        // continuation end, empty and short ping, pong, reserved opcode with
        // RSV bits set, empty non-final text frame
        queue_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 64'd0, FORM_SHORT, 0);
        queue_frame(1'b0, 3'b000, OP_BIN,  1'b1, 64'd1, FORM_SHORT, 1);
        queue_frame(1'b1, 3'b000, OP_CONT, 1'b0, 64'd1, FORM_EXT16, 1);
        queue_frame(1'b1, 3'b000, OP_PING, 1'b0, 64'd0, FORM_SHORT, 0);
        queue_frame(1'b1, 3'b000, OP_PING, 1'b0, 64'd1, FORM_SHORT, 1);
        queue_frame(1'b1, 3'b000, OP_PONG, 1'b0, 64'd0, FORM_SHORT, 0);
        queue_frame(1'b1, 3'b111, OP_RSV_CTRL_HI, 1'b0, 64'd1, FORM_SHORT, 1);
        queue_frame(1'b0, 3'b000, OP_TEXT, 1'b0, 64'd0, FORM_SHORT, 0);
        wait_idle();

        // Largest length limit, no close echo
        write_reg(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
        write_reg(CFG_ECHO_LIMIT, 32'd0);
        while (items_queued < 420)
            queue_random_frame(cur_max_len);
        // Sender pause: let every owed result drain before going on
        wait_idle();
        while (items_queued < 820)
            queue_random_frame(cur_max_len);
        wait_idle();

        // Zero length limit: only empty frames pass
        write_reg(CFG_MAX_PAYLOAD, 32'd0);
        repeat (30)
            queue_random_frame(cur_max_len);
        wait_idle();

        // Small random limit, echo limit above the saturation point
        write_reg(CFG_MAX_PAYLOAD, $urandom_range(20, 300));
        write_reg(CFG_ECHO_LIMIT, 32'd127);
        while (items_queued < 1780)
            queue_random_frame(cur_max_len);
        wait_idle();

        // Closing part: the block stays closed afterwards, so only one
        // way out per run
        ending = $urandom_range(END_CLOSE_FRAME, END_LINK_LOSS);
        r = $urandom_range(0, 6);
        case (r)
            0: write_reg(CFG_ECHO_LIMIT, 32'd0);
            1: write_reg(CFG_ECHO_LIMIT, 32'd1);
            2: write_reg(CFG_ECHO_LIMIT, 32'd2);
            3: write_reg(CFG_ECHO_LIMIT, 32'd125);
            4: write_reg(CFG_ECHO_LIMIT, 32'd126);
            5: write_reg(CFG_ECHO_LIMIT, 32'd127);
            default: write_reg(CFG_ECHO_LIMIT, $urandom_range(0, 127));
        endcase
        if (ending == END_OVERSIZE && $urandom_range(0, 1))
            write_reg(CFG_MAX_PAYLOAD, $urandom_range(0, 1000));
        else
            write_reg(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);

        case (ending)
            END_CLOSE_FRAME: begin
                ending_name = "a close frame";
                r = $urandom_range(0, 8);
                case (r)
                    4: len = 64'd124;
                    5: len = 64'd125;
                    6: len = 64'd126;
                    7: len = 64'd127;
                    8: len = 64'($urandom_range(4, 140));
                    default: len = 64'(r);
                endcase
                queue_frame(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), OP_CONN_CLOSE,
                            1'($urandom_range(0, 1)), len, pick_form(len), int'(len));
            end
            END_OVERSIZE: begin
                ending_name = "an oversized frame, then link loss";
                len = {32'h0, cur_max_len} + 64'd1 + 64'($urandom_range(0, 3));
                queue_frame(1'b1, 3'b000, OP_BIN, 1'($urandom_range(0, 1)), len,
                            pick_form(len), 0);
                // Dropped while the error holds
                n = $urandom_range(0, 8);
                repeat (n)
                    push_item(8'($urandom_range(0, 255)), 1'b0);
                push_item(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                ending_name = "link loss inside a frame";
                len = 64'($urandom_range(1, 20));
                queue_frame(1'b1, 3'b000, OP_TEXT, 1'($urandom_range(0, 1)), len,
                            pick_form(len), int'($urandom_range(0, int'(len) - 1)));
                push_item(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        // Everything after the close must be ignored
        n = $urandom_range(12, 24);
        repeat (n)
            push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        wait_idle();

        if (deframed_due.size() != 0)
            fail_count += deframed_due.size();

        $display("Sent %0d items in %0d frames over %0d register writes; checked %0d results.",
                 items_accepted, frames_queued, cfg_writes, results_checked);
        $display("Run ended with %s; %0d failures.", ending_name, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
